/* hdl/gcce_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none

package gcce_pkg;

  // Fixed field widths of the channels
  localparam int CMD_W      = 2;
  localparam int VIDX_W     = 6;
  localparam int ROW_IN_W   = 64;
  localparam int COLOR_IN_W = 8;
  localparam int CONF_W     = 13;
  localparam int DEG_W      = 7;
  localparam int MAXCOL_W   = 8;

  // Configuration port
  localparam int VCNT_W    = 7;
  localparam int PADDR_W   = 3;
  localparam int PDATA_W   = 32;
  localparam int REG_IDX_W = 1;

  localparam logic [REG_IDX_W-1:0] REG_VERTEX_COUNT = '0;
  localparam logic [VCNT_W-1:0]    VCNT_RESET       = 7'd64;

  // Defaults for the top-level parameters
  localparam int MAX_VERTICES_DEF = 64;
  localparam int COLOR_BITS_DEF   = 8;

  // Commands
  localparam logic [CMD_W-1:0] CMD_LOAD_ROW   = 2'd0;
  localparam logic [CMD_W-1:0] CMD_LOAD_COLOR = 2'd1;
  localparam logic [CMD_W-1:0] CMD_EVALUATE   = 2'd2;

endpackage

`default_nettype wire

/* hdl/gcce_ram.sv */
`timescale 1ns / 1ps
`default_nettype none

// Simple dual-port RAM, one write and one registered read port.
module gcce_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

/* hdl/graph_coloring_conflict_evaluator_core.sv */
// Graph coloring conflict evaluator.
// Input words carry a command: load an adjacency row (row_bits for vertex_index),
// load a vertex color, or evaluate. Loads give no output
// word. An evaluate walks the first n = min(vertex_count, MAX_VERTICES) rows and
// returns one output word: ordered same-color adjacent pairs, max row degree
// among used columns, and largest used color (all zero when n is zero).
// Rate: loads one per cycle while idle. An evaluate holds in_stall high until
// its result is handed to the output register (one column compare per cycle,
// set by the single read port of the color memory), and the output word
// appears in the same cycle that in_stall falls.
// The result sits in an output register; further loads are taken while it waits
// for the receiver, but a finished evaluate waits in its last state until the
// register is free, so out_stall can back up into in_stall.
// Config: vertex_count at byte address 0 over the APB-style port; the user must
// write it only while idle (not enforced by the block). Reset (rst_n low,
// synchronous) sets vertex_count to 64, clears the output valid and returns the
// sequencer to idle; memory contents stay as they are and must be loaded before use.
`timescale 1ns / 1ps
`default_nettype none

module graph_coloring_conflict_evaluator_core #(
  parameter int MAX_VERTICES = gcce_pkg::MAX_VERTICES_DEF,
  parameter int COLOR_BITS   = gcce_pkg::COLOR_BITS_DEF
) (
  input  wire logic                               clk,
  input  wire logic                               rst_n,
  // input channel
  input  wire logic                               in_valid,
  output logic                                    in_stall,
  input  wire logic [gcce_pkg::CMD_W-1:0]         in_command,
  input  wire logic [gcce_pkg::VIDX_W-1:0]        in_vertex_index,
  input  wire logic [gcce_pkg::ROW_IN_W-1:0]      in_row_bits,
  input  wire logic [gcce_pkg::COLOR_IN_W-1:0]    in_color_value,
  // result channel
  output logic                                    out_valid,
  input  wire logic                               out_stall,
  output logic      [gcce_pkg::CONF_W-1:0]        out_conflict_count,
  output logic      [gcce_pkg::DEG_W-1:0]         out_max_degree,
  output logic      [gcce_pkg::MAXCOL_W-1:0]      out_max_color,
  // configuration port
  input  wire logic                               psel,
  input  wire logic                               penable,
  input  wire logic                               pwrite,
  input  wire logic [gcce_pkg::PADDR_W-1:0]       paddr,
  input  wire logic [gcce_pkg::PDATA_W-1:0]       pwdata,
  output logic      [gcce_pkg::PDATA_W-1:0]       prdata,
  output logic                                    pready
);

  import gcce_pkg::*;

  localparam int IDX_W = $clog2(MAX_VERTICES);
  localparam int CNT_W = $clog2(MAX_VERTICES + 1);

  typedef enum logic [3:0] {
    S_IDLE  = 4'b0001,
    S_RDROW = 4'b0010,
    S_SCAN  = 4'b0100,
    S_DONE  = 4'b1000
  } state_t;

  // Row latch is a sub-step folded into the scan entry (see jv_r / latch_r).

  // ---------------------------------------------------------------------------
  // Configuration register
  // ---------------------------------------------------------------------------
  logic [VCNT_W-1:0]    vcount_r;
  logic                 cfg_wr;
  logic [REG_IDX_W-1:0] cfg_reg;

  assign pready = 1'b1;
  assign cfg_reg = paddr[PADDR_W-1:PADDR_W-REG_IDX_W];
  assign cfg_wr  = psel && penable && pwrite && pready && (cfg_reg == REG_VERTEX_COUNT);

  always_comb begin
    prdata = '0;
    if (cfg_reg == REG_VERTEX_COUNT) begin
      prdata = PDATA_W'(vcount_r);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vcount_r <= VCNT_RESET;
    end else if (cfg_wr) begin
      vcount_r <= pwdata[VCNT_W-1:0];
    end
  end

  // ---------------------------------------------------------------------------
  // Sequencer state
  // ---------------------------------------------------------------------------
  state_t                state_r, state_nxt;
  logic                  latch_r, latch_nxt;   // first scan cycle: row data on RAM out
  logic                  jv_r, jv_nxt;         // color read in flight for column jd_r
  logic [CNT_W-1:0]      n_r, n_nxt;
  logic [CNT_W-1:0]      i_r, i_nxt;
  logic [CNT_W-1:0]      j_r, j_nxt;
  logic [IDX_W-1:0]      jd_r, jd_nxt;
  logic [MAX_VERTICES-1:0] row_r, row_nxt;
  logic [COLOR_BITS-1:0] coli_r, coli_nxt;
  logic [DEG_W-1:0]      deg_r, deg_nxt;
  logic [DEG_W-1:0]      maxdeg_r, maxdeg_nxt;
  logic [COLOR_BITS-1:0] maxcol_r, maxcol_nxt;
  logic [CONF_W-1:0]     conf_r, conf_nxt;

  logic                  out_valid_r, out_valid_nxt;
  logic [CONF_W-1:0]     out_conf_r, out_conf_nxt;
  logic [DEG_W-1:0]      out_deg_r, out_deg_nxt;
  logic [MAXCOL_W-1:0]   out_col_r, out_col_nxt;

  logic                  in_acc;
  logic                  idx_ok;
  logic                  adj_we, col_we;
  logic [CNT_W-1:0]      n_clamp;
  logic [CNT_W-1:0]      i_inc;
  logic                  out_free;

  logic [IDX_W-1:0]        adj_raddr, col_raddr;
  logic [MAX_VERTICES-1:0] adj_rdata;
  logic [COLOR_BITS-1:0]   col_rdata;

  assign in_stall = (state_r != S_IDLE);
  assign in_acc   = in_valid && !in_stall;
  assign idx_ok   = ({1'b0, in_vertex_index} < (VIDX_W + 1)'(MAX_VERTICES));
  assign adj_we   = in_acc && (in_command == CMD_LOAD_ROW) && idx_ok;
  assign col_we   = in_acc && (in_command == CMD_LOAD_COLOR) && idx_ok;

  assign n_clamp  = (vcount_r > VCNT_W'(MAX_VERTICES)) ? CNT_W'(MAX_VERTICES)
                                                      : CNT_W'(vcount_r);
  assign i_inc    = i_r + CNT_W'(1);
  assign out_free = !out_valid_r || !out_stall;

  // Row and color of vertex i are read in S_RDROW; columns are read in S_SCAN.
  assign adj_raddr = i_r[IDX_W-1:0];
  assign col_raddr = (state_r == S_RDROW) ? i_r[IDX_W-1:0] : j_r[IDX_W-1:0];

  // ---------------------------------------------------------------------------
  // Memories. Writes happen only while idle and an evaluate reads only after it
  // is taken, so a read never overlaps a write to the same entry.
  // ---------------------------------------------------------------------------
  gcce_ram #(
    .WIDTH (MAX_VERTICES),
    .DEPTH (MAX_VERTICES)
  ) u_adj_ram (
    .clk   (clk),
    .we    (adj_we),
    .waddr (in_vertex_index[IDX_W-1:0]),
    .wdata (in_row_bits[MAX_VERTICES-1:0]),
    .raddr (adj_raddr),
    .rdata (adj_rdata)
  );

  gcce_ram #(
    .WIDTH (COLOR_BITS),
    .DEPTH (MAX_VERTICES)
  ) u_col_ram (
    .clk   (clk),
    .we    (col_we),
    .waddr (in_vertex_index[IDX_W-1:0]),
    .wdata (COLOR_BITS'(in_color_value)),
    .raddr (col_raddr),
    .rdata (col_rdata)
  );

  // ---------------------------------------------------------------------------
  // Next-state logic
  // ---------------------------------------------------------------------------
  always_comb begin
    state_nxt  = state_r;
    latch_nxt  = 1'b0;
    jv_nxt     = jv_r;
    n_nxt      = n_r;
    i_nxt      = i_r;
    j_nxt      = j_r;
    jd_nxt     = jd_r;
    row_nxt    = row_r;
    coli_nxt   = coli_r;
    deg_nxt    = deg_r;
    maxdeg_nxt = maxdeg_r;
    maxcol_nxt = maxcol_r;
    conf_nxt   = conf_r;

    out_valid_nxt = out_valid_r && out_stall;
    out_conf_nxt  = out_conf_r;
    out_deg_nxt   = out_deg_r;
    out_col_nxt   = out_col_r;

    unique case (state_r)
      S_IDLE: begin
        if (in_acc && (in_command == CMD_EVALUATE)) begin
          n_nxt      = n_clamp;
          i_nxt      = '0;
          conf_nxt   = '0;
          maxdeg_nxt = '0;
          maxcol_nxt = '0;
          state_nxt  = (n_clamp == '0) ? S_DONE : S_RDROW;
        end
      end
      S_RDROW: begin
        j_nxt     = '0;
        latch_nxt = 1'b1;
        state_nxt = S_SCAN;
      end
      S_SCAN: begin
        if (latch_r) begin
          // row i and its color are on the RAM outputs; first column read goes out
          row_nxt  = adj_rdata;
          coli_nxt = col_rdata;
          if (col_rdata > maxcol_r) begin
            maxcol_nxt = col_rdata;
          end
          deg_nxt = '0;
          jd_nxt  = '0;
          j_nxt   = CNT_W'(1);
          jv_nxt  = 1'b1;
        end else if (jv_r) begin
          if (row_r[jd_r]) begin
            deg_nxt = deg_r + DEG_W'(1);
            if (col_rdata == coli_r) begin
              conf_nxt = conf_r + CONF_W'(1);
            end
          end
          if (j_r < n_r) begin
            jd_nxt = j_r[IDX_W-1:0];
            j_nxt  = j_r + CNT_W'(1);
          end else begin
            jv_nxt = 1'b0;
          end
        end else begin
          // row finished
          if (deg_r > maxdeg_r) begin
            maxdeg_nxt = deg_r;
          end
          i_nxt     = i_inc;
          state_nxt = (i_inc < n_r) ? S_RDROW : S_DONE;
        end
      end
      S_DONE: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
          out_conf_nxt  = conf_r;
          out_deg_nxt   = maxdeg_r;
          out_col_nxt   = MAXCOL_W'(maxcol_r);
          state_nxt     = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      latch_r     <= 1'b0;
      jv_r        <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      latch_r     <= latch_nxt;
      jv_r        <= jv_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    n_r        <= n_nxt;
    i_r        <= i_nxt;
    j_r        <= j_nxt;
    jd_r       <= jd_nxt;
    row_r      <= row_nxt;
    coli_r     <= coli_nxt;
    deg_r      <= deg_nxt;
    maxdeg_r   <= maxdeg_nxt;
    maxcol_r   <= maxcol_nxt;
    conf_r     <= conf_nxt;
    out_conf_r <= out_conf_nxt;
    out_deg_r  <= out_deg_nxt;
    out_col_r  <= out_col_nxt;
  end

  assign out_valid          = out_valid_r;
  assign out_conflict_count = out_conf_r;
  assign out_max_degree     = out_deg_r;
  assign out_max_color      = out_col_r;

  // ---------------------------------------------------------------------------
  // Assertions
  // ---------------------------------------------------------------------------
  a_wr_only_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (adj_we || col_we) |-> (state_r == S_IDLE))
    else $error("memory write outside idle");

  a_valid_from_done: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(state_r == S_DONE))
    else $error("output valid not raised by a finished evaluate");

  a_done_all_rows: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_DONE) |-> (i_r == n_r))
    else $error("evaluate finished before walking all rows");

  a_col_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    ((state_r == S_SCAN) && !latch_r && jv_r) |-> (CNT_W'(jd_r) < n_r))
    else $error("column compare beyond vertex count");

  a_scan_after_row: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_RDROW) |=> ((state_r == S_SCAN) && latch_r))
    else $error("row read not followed by latch");

endmodule

`default_nettype wire
